[rtl/rdt_pkg.sv]
// Package for the RTC drift trim calculator: time constants, field widths and
// sequencer step counts shared by the core.
// No dependencies.
package rdt_pkg;

   localparam int DAY_SECONDS       = 86400;
   localparam int HALF_DAY_SECONDS  = 43200;
   localparam int MIN_ELAPSED       = 86400 - 600;

   localparam int TIME_BITS         = 32;
   localparam int TOD_BITS          = 17;   // holds 0..86399
   localparam int DIFF_BITS         = 16;   // magnitude of wrapped difference, <= 43200
   localparam int SCALE_BITS        = 20;   // correction is in pulses per 2^20
   localparam int DVD_BITS          = DIFF_BITS + SCALE_BITS;
   localparam int QUO_BITS          = 20;   // |quotient| <= 43200 * 2^20 / 85801 < 2^20
   localparam int W_BITS            = 21;   // signed trial calibration word
   localparam int CAL_BITS          = 7;
   localparam int PRESC_BITS        = 16;
   localparam int STEP_BITS         = 6;

   localparam int MOD_STEPS         = TIME_BITS;
   localparam int DIV_STEPS         = DVD_BITS;

   localparam logic [CAL_BITS-1:0]   CAL_DEFAULT       = 7'd63;
   localparam logic [CAL_BITS-1:0]   CAL_RECENTER      = 7'd64;
   localparam logic [PRESC_BITS-1:0] PRESCALER_DEFAULT = 16'h8000 - 16'd2;
   localparam logic [PRESC_BITS-1:0] PRESCALER_BIAS    = 16'd2;

   localparam logic [0:0] MODE_SET = 1'b0;

   typedef logic [TIME_BITS-1:0] time_type;

endpackage

[rtl/rtc_drift_trim_calculator_core.sv]
// RTC drift trim calculator: sets the seconds counter and trims the clock rate.
// Sequence: the bit-serial mod-86400 units, the time-of-day difference, the
// bit-serial divider, the trial word, then the rsp register; req is stalled
// while a word is at work, so a new word is taken only once the last is done.
// Reset (synchronous): calibration 63, prescaler 32766, no trim time stored.
// Depends on rdt_pkg.
module rtc_drift_trim_calculator_core
   import rdt_pkg::*;
#(
   parameter int COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_new_time,
   input  logic [31:0] req_counter_now,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_counter_load,
   output logic [6:0]  rsp_cal_out,
   output logic [15:0] rsp_prescaler_out,
   output logic        rsp_trimmed
);

   // Only the low COUNT_BITS bits of the time inputs take part.
   localparam time_type CNT_MASK = 32'hFFFF_FFFF >> (TIME_BITS - COUNT_BITS);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a req word
   localparam logic [2:0] ST_MOD  = 3'd1;  // both times mod 86400, one bit a cycle
   localparam logic [2:0] ST_DIFF = 3'd2;  // wrap the time-of-day difference to +-12 h
   localparam logic [2:0] ST_DIV  = 3'd3;  // |d| * 2^20 / elapsed, one bit a cycle
   localparam logic [2:0] ST_ADJ  = 3'd4;  // trial calibration word
   localparam logic [2:0] ST_FIN  = 3'd5;  // commit state and load the rsp register

   localparam logic [TOD_BITS:0] DAY_WIDE = (TOD_BITS + 1)'(DAY_SECONDS);
   localparam logic signed [TOD_BITS:0] HALF_DAY_POS = (TOD_BITS + 1)'(HALF_DAY_SECONDS);
   localparam logic signed [TOD_BITS:0] HALF_DAY_NEG = -HALF_DAY_POS;
   localparam logic signed [TOD_BITS:0] DAY_SIGNED   = (TOD_BITS + 1)'(DAY_SECONDS);
   localparam time_type MIN_ELAPSED_T = TIME_BITS'(MIN_ELAPSED);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   logic [2:0]           state_ff, state_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 mode_ff, mode_in;
   logic                 trim_ok_ff, trim_ok_in;
   time_type             new_ff, new_in;        // rotates back to its value after MOD
   time_type             now_ff, now_in;        // shifts out MSB first
   time_type             elapsed_ff, elapsed_in;
   logic [TOD_BITS-1:0]  tod_new_ff, tod_new_in;
   logic [TOD_BITS-1:0]  tod_now_ff, tod_now_in;
   logic [DVD_BITS-1:0]  dvd_ff, dvd_in;
   time_type             rem_ff, rem_in;
   logic [QUO_BITS-1:0]  quo_ff, quo_in;
   logic                 neg_ff, neg_in;
   logic [W_BITS-1:0]    w_ff, w_in;

   logic [CAL_BITS-1:0]   cal_ff, cal_in;
   logic [PRESC_BITS-1:0] presc_ff, presc_in;
   time_type              last_ff, last_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   time_type              rsp_load_ff, rsp_load_in;
   logic [CAL_BITS-1:0]   rsp_cal_ff, rsp_cal_in;
   logic [PRESC_BITS-1:0] rsp_presc_ff, rsp_presc_in;
   logic                  rsp_trim_ff, rsp_trim_in;

   // ---------------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------------
   logic                    req_fire;
   logic                    rsp_free;
   time_type                new_masked;
   time_type                now_masked;
   time_type                elapsed_raw;
   logic [TOD_BITS:0]       tod_new_wide;
   logic [TOD_BITS:0]       tod_now_wide;
   logic signed [TOD_BITS:0] diff;
   logic signed [TOD_BITS:0] diff_wrap;
   logic [TOD_BITS:0]       diff_mag;
   logic [TIME_BITS:0]      div_wide;
   logic [TIME_BITS:0]      div_sub;
   logic                    div_ge;
   logic                    w_in_range;
   logic [W_BITS-1:0]       w_neg;
   logic [W_BITS-2:0]       w_mag;
   logic [W_BITS-7:0]       w_steps;
   logic [4:0]              w_rest;
   logic [PRESC_BITS-1:0]   presc_adj;
   logic [CAL_BITS-1:0]     cal_adj;

   assign req_fire   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign new_masked = req_new_time & CNT_MASK;
   assign now_masked = req_counter_now & CNT_MASK;
   assign elapsed_raw = (now_masked - last_ff) & CNT_MASK;

   // One restoring step of each mod-86400 unit: shift in the next bit, subtract once.
   always_comb begin
      tod_new_wide = {tod_new_ff, new_ff[TIME_BITS-1]};
      if (tod_new_wide >= DAY_WIDE) begin
         tod_new_wide = tod_new_wide - DAY_WIDE;
      end
      tod_now_wide = {tod_now_ff, now_ff[TIME_BITS-1]};
      if (tod_now_wide >= DAY_WIDE) begin
         tod_now_wide = tod_now_wide - DAY_WIDE;
      end
   end

   // Time-of-day difference, folded into -12 h .. +12 h.
   always_comb begin
      diff = $signed({1'b0, tod_new_ff}) - $signed({1'b0, tod_now_ff});
      diff_wrap = diff;
      if (diff > HALF_DAY_POS) begin
         diff_wrap = diff - DAY_SIGNED;
      end else if (diff < HALF_DAY_NEG) begin
         diff_wrap = diff + DAY_SIGNED;
      end
      diff_mag = diff_wrap[TOD_BITS] ? (TOD_BITS + 1)'(-diff_wrap) : diff_wrap;
   end

   // One restoring divider step; the remainder stays below the divisor.
   assign div_wide = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign div_ge   = div_wide >= {1'b0, elapsed_ff};
   assign div_sub  = div_wide - {1'b0, elapsed_ff};

   // Carry whole steps of 32 into the prescaler when the word leaves 0..127.
   assign w_in_range = !w_ff[W_BITS-1] && (w_ff[W_BITS-2:CAL_BITS] == '0);
   assign w_neg      = ~w_ff + W_BITS'(1);
   assign w_mag      = w_ff[W_BITS-1] ? w_neg[W_BITS-2:0] : w_ff[W_BITS-2:0];
   assign w_steps    = w_mag[W_BITS-2:5];
   assign w_rest     = w_mag[4:0];

   always_comb begin
      if (w_ff[W_BITS-1]) begin
         presc_adj = presc_ff - PRESC_BITS'(w_steps) - PRESCALER_BIAS;
         cal_adj   = CAL_RECENTER - {2'b0, w_rest};
      end else begin
         presc_adj = presc_ff + PRESC_BITS'(w_steps) - PRESCALER_BIAS;
         cal_adj   = CAL_RECENTER + {2'b0, w_rest};
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer and next-state logic
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      mode_in      = mode_ff;
      trim_ok_in   = trim_ok_ff;
      new_in       = new_ff;
      now_in       = now_ff;
      elapsed_in   = elapsed_ff;
      tod_new_in   = tod_new_ff;
      tod_now_in   = tod_now_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      w_in         = w_ff;
      cal_in       = cal_ff;
      presc_in     = presc_ff;
      last_in      = last_ff;
      rsp_load_in  = rsp_load_ff;
      rsp_cal_in   = rsp_cal_ff;
      rsp_presc_in = rsp_presc_ff;
      rsp_trim_in  = rsp_trim_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Capture the word; decide now whether a trim is due, since it
               // depends only on the mode, the stored trim time and the live counter.
               mode_in    = req_mode;
               new_in     = new_masked;
               now_in     = now_masked;
               elapsed_in = elapsed_raw;
               trim_ok_in = (req_mode != MODE_SET) && (last_ff != '0)
                            && !elapsed_raw[COUNT_BITS-1]
                            && (elapsed_raw > MIN_ELAPSED_T);
               tod_new_in = '0;
               tod_now_in = '0;
               step_in    = '0;
               state_in   = ST_MOD;
            end
         end
         ST_MOD: begin
            tod_new_in = tod_new_wide[TOD_BITS-1:0];
            tod_now_in = tod_now_wide[TOD_BITS-1:0];
            new_in     = {new_ff[TIME_BITS-2:0], new_ff[TIME_BITS-1]};
            now_in     = {now_ff[TIME_BITS-2:0], 1'b0};
            step_in    = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(MOD_STEPS - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            neg_in   = diff_wrap[TOD_BITS];
            dvd_in   = {diff_mag[DIFF_BITS-1:0], {SCALE_BITS{1'b0}}};
            rem_in   = '0;
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_sub[TIME_BITS-1:0] : div_wide[TIME_BITS-1:0];
            quo_in  = {quo_ff[QUO_BITS-2:0], div_ge};
            dvd_in  = {dvd_ff[DVD_BITS-2:0], 1'b0};
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            // quo is unsigned, neg_ff the sign of d: subtracting -quo adds it.
            if (neg_ff) begin
               w_in = W_BITS'(cal_ff) + W_BITS'(quo_ff);
            end else begin
               w_in = W_BITS'(cal_ff) - W_BITS'(quo_ff);
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // Hold here until the rsp register is free.
            if (rsp_free) begin
               if (mode_ff == MODE_SET) begin
                  cal_in   = CAL_DEFAULT;
                  presc_in = PRESCALER_DEFAULT;
               end else if (trim_ok_ff) begin
                  if (w_in_range) begin
                     cal_in = w_ff[CAL_BITS-1:0];
                  end else begin
                     cal_in   = cal_adj;
                     presc_in = presc_adj;
                  end
               end
               last_in      = new_ff;
               rsp_load_in  = new_ff;
               rsp_cal_in   = cal_in;
               rsp_presc_in = presc_in;
               rsp_trim_in  = trim_ok_ff && (mode_ff != MODE_SET);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_ff       <= CAL_DEFAULT;
         presc_ff     <= PRESCALER_DEFAULT;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cal_ff       <= cal_in;
         presc_ff     <= presc_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers need no reset.
   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      mode_ff      <= mode_in;
      trim_ok_ff   <= trim_ok_in;
      new_ff       <= new_in;
      now_ff       <= now_in;
      elapsed_ff   <= elapsed_in;
      tod_new_ff   <= tod_new_in;
      tod_now_ff   <= tod_now_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      neg_ff       <= neg_in;
      w_ff         <= w_in;
      rsp_load_ff  <= rsp_load_in;
      rsp_cal_ff   <= rsp_cal_in;
      rsp_presc_ff <= rsp_presc_in;
      rsp_trim_ff  <= rsp_trim_in;
   end

   // ---------------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------------
   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_load  = rsp_load_ff;
   assign rsp_cal_out       = rsp_cal_ff;
   assign rsp_prescaler_out = rsp_presc_ff;
   assign rsp_trimmed       = rsp_trim_ff;

endmodule

[tb/tb_rtc_drift_trim_calculator_core.sv]
// Self-checking testbench for rtc_drift_trim_calculator_core: drives set and calibrate
// commands, predicts counter load, calibration word and prescaler, and checks each rsp word.
// Depends on rdt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_rtc_drift_trim_calculator_core;
   import rdt_pkg::*;

   localparam logic [0:0] MODE_CAL    = 1'b1;
   localparam int         CYCLE_LIMIT = 2_000_000;
   localparam int         DRAIN_WAIT  = 80;    // wait after the last phase before the final count

   typedef struct {
      logic [0:0]  mode;
      logic [31:0] new_time;
      logic [31:0] counter_now;
   } trim_cmd_type;

   typedef struct {
      logic [31:0] counter_load;
      logic [6:0]  cal;
      logic [15:0] prescaler;
      logic        trimmed;
   } trim_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_mode        = 1'b0;
   logic [31:0] req_new_time    = '0;
   logic [31:0] req_counter_now = '0;

   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [31:0] rsp_counter_load;
   logic [6:0]  rsp_cal_out;
   logic [15:0] rsp_prescaler_out;
   logic        rsp_trimmed;

   rtc_drift_trim_calculator_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_new_time      (req_new_time),
      .req_counter_now   (req_counter_now),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_counter_load  (rsp_counter_load),
      .rsp_cal_out       (rsp_cal_out),
      .rsp_prescaler_out (rsp_prescaler_out),
      .rsp_trimmed       (rsp_trimmed)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Commands waiting for the driver, and results owed by the core, oldest first.
   trim_cmd_type    cmd_backlog[$];
   trim_result_type owed_results[$];
   trim_cmd_type    cur_cmd;

   // Shadow of the trim state, advanced once per accepted req word.
   logic [6:0]  cal_track;
   logic [15:0] presc_track;
   logic [31:0] last_trim_track;

   // Last new_time handed to the backlog: lets the generator build elapsed times.
   logic [31:0] gen_last;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int n_queued      = 0;
   int n_checked     = 0;
   int n_fail        = 0;
   int n_trims       = 0;
   int n_presc_moves = 0;
   int cycles        = 0;

   // Work out one command's effect on the trim state and the word it must produce.
   function automatic trim_result_type trim_predict(trim_cmd_type c);
      trim_result_type r;
      longint          tod_diff, quo, trial, presc_next;
      logic [31:0]     elapsed;
      r.trimmed = 1'b0;
      if (c.mode == MODE_SET) begin
         cal_track   = CAL_DEFAULT;
         presc_track = PRESCALER_DEFAULT;
      end else if (last_trim_track != 0) begin
         // time-of-day error, folded into plus or minus half a day
         tod_diff = (longint'(c.new_time) % DAY_SECONDS) -
                    (longint'(c.counter_now) % DAY_SECONDS);
         if (tod_diff > HALF_DAY_SECONDS)
            tod_diff -= DAY_SECONDS;
         if (tod_diff < -HALF_DAY_SECONDS)
            tod_diff += DAY_SECONDS;
         elapsed = c.counter_now - last_trim_track;
         // a backward elapsed time (sign bit set) or one not over a day less ten minutes: no trim
         if (!elapsed[31] && elapsed > MIN_ELAPSED) begin
            quo   = (tod_diff * 64'sd1048576) / longint'(elapsed);
            trial = longint'(cal_track) - quo;
            if (trial < 0 || trial > 127) begin
               // move whole steps of 32 into the prescaler, recenter the word on 64
               presc_next  = longint'(presc_track) + trial / 32 - 2;
               presc_track = presc_next[15:0];
               trial       = 64 + (trial - (trial / 32) * 32);
               n_presc_moves++;
            end
            cal_track = trial[6:0];
            r.trimmed = 1'b1;
            n_trims++;
         end
      end
      last_trim_track = c.new_time;
      r.counter_load  = c.new_time;
      r.cal           = cal_track;
      r.prescaler     = presc_track;
      return r;
   endfunction

   task automatic push_cmd(logic [0:0] mode, logic [31:0] new_time, logic [31:0] counter_now);
      trim_cmd_type c;
      c.mode        = mode;
      c.new_time    = new_time;
      c.counter_now = counter_now;
      cmd_backlog.push_back(c);
      gen_last = new_time;
      n_queued++;
   endtask

   // Calibrate command whose counter has run for elapsed seconds since the last set time.
   task automatic push_rel(int unsigned elapsed, int drift);
      logic [31:0] now;
      now = gen_last + elapsed;
      push_cmd(MODE_CAL, now + drift, now);
   endtask

   // Calibrate command with chosen times of day, on the day reached elapsed seconds on.
   task automatic push_tod(int unsigned elapsed, int unsigned new_tod, int unsigned now_tod);
      logic [31:0] day_start;
      day_start = gen_last + elapsed;
      day_start = day_start - day_start % DAY_SECONDS;
      push_cmd(MODE_CAL, day_start + new_tod, day_start + now_tod);
   endtask

   task automatic push_random();
      int unsigned kind, elapsed;
      int          drift;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         push_cmd(MODE_SET, ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom(), $urandom());
      end else if (kind < 16) begin
         push_cmd(1'($urandom_range(0, 1)), $urandom(), $urandom());
      end else if (kind < 24) begin
         // too short or running backward: time is set, nothing trimmed
         elapsed = $urandom_range(0, 1) ? $urandom_range(0, MIN_ELAPSED)
                                        : (32'h8000_0000 | $urandom());
         push_rel(elapsed, int'($urandom_range(0, 1200)) - 600);
      end else begin
         case ($urandom_range(0, 9))
            0:       elapsed = MIN_ELAPSED + $urandom_range(1, 3);
            1:       elapsed = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
            default: elapsed = $urandom_range(MIN_ELAPSED + 1, DAY_SECONDS * 60);
         endcase
         case ($urandom_range(0, 4))
            0:       drift = int'($urandom_range(0, 2 * HALF_DAY_SECONDS)) - HALF_DAY_SECONDS;
            1, 2:    drift = int'($urandom_range(0, 16)) - 8;
            default: drift = int'($urandom_range(0, 1200)) - 600;
         endcase
         push_rel(elapsed, drift);
      end
   endtask

   // Driver: record the word taken at this edge, then present the next one or go idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            owed_results.push_back(trim_predict(cur_cmd));
         if (!req_valid || !req_stall) begin
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_cmd         = cmd_backlog.pop_front();
               req_valid       <= 1'b1;
               req_mode        <= cur_cmd.mode;
               req_new_time    <= cur_cmd.new_time;
               req_counter_now <= cur_cmd.counter_now;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each rsp word against the oldest owed result, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
               $display("unexpected rsp word: load %h cal %0d presc %0d trimmed %0d",
                        rsp_counter_load, rsp_cal_out, rsp_prescaler_out, rsp_trimmed);
         end else begin
            trim_result_type want;
            want = owed_results.pop_front();
            if (rsp_counter_load !== want.counter_load || rsp_cal_out !== want.cal ||
                rsp_prescaler_out !== want.prescaler || rsp_trimmed !== want.trimmed) begin
               n_fail++;
               if (n_fail <= 10)
                  $display({"rsp word %0d wrong (expected/actual): load %h/%h cal %0d/%0d",
                            " presc %0d/%0d trimmed %0d/%0d"}, n_checked,
                           want.counter_load, rsp_counter_load, want.cal, rsp_cal_out,
                           want.prescaler, rsp_prescaler_out, want.trimmed, rsp_trimmed);
            end
         end
         n_checked++;
      end
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d words checked",
                  cycles, n_checked, n_queued);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      int phase_send[4]  = '{0, 88, 0, 12};
      int phase_stall[4] = '{0, 0, 88, 12};
      cal_track       = CAL_DEFAULT;
      presc_track     = PRESCALER_DEFAULT;
      last_trim_track = '0;
      gen_last        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed words, no idling.
      push_cmd(MODE_CAL, 32'h0000_1000, 32'hFFFF_FFFF);   // nothing stored yet
      push_cmd(MODE_SET, 32'd0, 32'd0);                    // store a zero time
      push_rel(2 * DAY_SECONDS, 50);                       // zero stored counts as none
      push_rel(MIN_ELAPSED, 10);                           // right at the threshold
      push_rel(MIN_ELAPSED + 1, 1);                        // first trim, word stays in range
      push_cmd(MODE_SET, 32'd1_000_000, 32'd999_000);
      push_rel(DAY_SECONDS, 30);                           // word goes below zero
      push_rel(DAY_SECONDS, -30);                          // word goes above 127
      push_rel(32'hFFFF_FFFB, 0);                          // counter ran backward
      push_rel(32'h8000_0000, 100);                        // elapsed sign bit set
      push_rel(32'h7FFF_FFFF, 600);                        // longest forward elapsed
      push_cmd(MODE_SET, 32'd5000, 32'd0);
      push_tod(3 * DAY_SECONDS, 86399, 0);                 // fold down to -1
      push_tod(3 * DAY_SECONDS, 0, 86399);                 // fold up to +1
      push_tod(3 * DAY_SECONDS, HALF_DAY_SECONDS, 0);      // +12 h stays
      push_tod(3 * DAY_SECONDS, 0, HALF_DAY_SECONDS);      // -12 h stays
      push_tod(3 * DAY_SECONDS, HALF_DAY_SECONDS + 1, 0);  // just past +12 h
      push_rel(DAY_SECONDS, 3);
      push_rel(DAY_SECONDS, 3);
      push_cmd(MODE_CAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_cmd(MODE_SET, 32'hFFFF_FFFF, 32'h0000_0000);
      push_cmd(MODE_CAL, 32'h0000_0000, 32'hFFFF_FFFF);    // zero elapsed
      wait (n_checked == n_queued);

      // Random phases; hold the sender between them until every result is back.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = phase_send[ph];
         stall_pct     = phase_stall[ph];
         repeat (170) push_random();
         wait (n_checked == n_queued);
      end
      stall_pct = 0;
      repeat (DRAIN_WAIT) @(posedge clock);

      n_fail += owed_results.size();
      $display("checked %0d of %0d words: %0d drift trims, %0d spilled into the prescaler",
               n_checked, n_queued, n_trims, n_presc_moves);
      if (n_fail == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures", n_fail);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
